>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands for the tokenizer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ON_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_AFTER_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) rst |=> (prop)) \
    else $error("reset assertion failed");
`else
`define ASSERT_ON_CLK(label, clk, rst, prop)
`define ASSERT_AFTER_RST(label, clk, rst, prop)
`endif

`endif

>>> rtl/core/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// shared types, character codes and classifiers of the script tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sct_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int MAX_RES = 3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  typedef enum logic [0:0] {
    ITEM_CONTENT = 1'b0,
    ITEM_END     = 1'b1
  } item_kind_t;

  typedef enum logic [2:0] {
    TK_WORD    = 3'd0,
    TK_NUMBER  = 3'd1,
    TK_TEXT    = 3'd2,
    TK_CHARS   = 3'd3,
    TK_CONTENT = 3'd4,
    TK_SPECIAL = 3'd5,
    TK_LINEEND = 3'd6
  } tok_kind_t;

  typedef enum logic [9:0] {
    M_IDLE    = 10'b00_0000_0001,
    M_WORD    = 10'b00_0000_0010,
    M_NUMBER  = 10'b00_0000_0100,
    M_INCLUDE = 10'b00_0000_1000,
    M_TEXT    = 10'b00_0001_0000,
    M_CHARS   = 10'b00_0010_0000,
    M_CONTENT = 10'b00_0100_0000,
    M_COMMENT = 10'b00_1000_0000,
    M_LINEEND = 10'b01_0000_0000,
    M_SKIPCMT = 10'b10_0000_0000
  } lex_mode_t;

  typedef struct packed {
    item_kind_t kind;
    tok_kind_t  tk;
    logic [7:0] ch;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t [MAX_RES-1:0] res;
  } grp_t;

  function automatic res_t mk_res(input item_kind_t kind, input tok_kind_t tk,
                                  input logic [7:0] ch);
    res_t r;
    r.kind = kind;
    r.tk   = tk;
    r.ch   = (kind == ITEM_END) ? 8'h00 : ch;
    return r;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h61:8'h7a], [8'h41:8'h5a]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]});
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

>>> rtl/core/sct_front.sv
// ----------------------------------------------------------------------------
// sct_front
// lexer state and per-byte classification into a group of up to three words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sct_front
  import sct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] in_char,
  output grp_t       grp,
  output logic       grp_valid
);

  lex_mode_t lex_mode, lex_mode_next;
  logic      held_bs, held_bs_next;

  always_comb begin
    logic [1:0] n;
    logic       redo;
    logic [7:0] b;
    logic [7:0] q;
    tok_kind_t  qk;
    logic       esc_bs;
    n             = 2'd0;
    redo          = 1'b0;
    b             = in_char;
    grp           = '0;
    lex_mode_next = lex_mode;
    held_bs_next  = held_bs;
    q             = (lex_mode == M_TEXT) ? CH_DQUOTE : CH_SQUOTE;
    qk            = (lex_mode == M_TEXT) ? TK_TEXT : TK_CHARS;
    esc_bs        = (lex_mode == M_TEXT);

    case (lex_mode)
      M_WORD, M_NUMBER: begin
        if (is_alpha(b) || is_digit(b) ||
            (lex_mode == M_WORD && b == CH_USCORE) ||
            (lex_mode == M_NUMBER && b == CH_DOT)) begin
          grp.res[n] = mk_res(ITEM_CONTENT, (lex_mode == M_WORD) ? TK_WORD : TK_NUMBER, b);
          n = n + 2'd1;
        end else begin
          grp.res[n] = mk_res(ITEM_END, (lex_mode == M_WORD) ? TK_WORD : TK_NUMBER, b);
          n = n + 2'd1;
          redo = 1'b1;
        end
      end
      M_INCLUDE: begin
        if (b == CH_NUL || b == CH_HASH) lex_mode_next = M_IDLE;
      end
      M_TEXT, M_CHARS: begin
        if (held_bs && (b == q || (esc_bs && b == CH_BSLASH))) begin
          held_bs_next = 1'b0;
          grp.res[n] = mk_res(ITEM_CONTENT, qk, b);
          n = n + 2'd1;
        end else begin
          held_bs_next = 1'b0;
          if (b == CH_BSLASH) begin
            grp.res[n] = mk_res(ITEM_CONTENT, qk, b);
            n = n + 2'd1;
            held_bs_next = 1'b1;
          end else if (b == q) begin
            grp.res[n] = mk_res(ITEM_CONTENT, qk, b);
            n = n + 2'd1;
            grp.res[n] = mk_res(ITEM_END, qk, b);
            n = n + 2'd1;
            lex_mode_next = M_IDLE;
          end else if (b == CH_NUL || is_eol(b)) begin
            grp.res[n] = mk_res(ITEM_CONTENT, qk, q);
            n = n + 2'd1;
            grp.res[n] = mk_res(ITEM_END, qk, b);
            n = n + 2'd1;
            redo = 1'b1;
          end else begin
            grp.res[n] = mk_res(ITEM_CONTENT, qk, b);
            n = n + 2'd1;
          end
        end
      end
      M_CONTENT: begin
        if (b == CH_RBRACE) begin
          held_bs_next = 1'b0;
          if (held_bs) begin
            grp.res[n] = mk_res(ITEM_CONTENT, TK_CONTENT, b);
            n = n + 2'd1;
          end else begin
            grp.res[n] = mk_res(ITEM_END, TK_CONTENT, b);
            n = n + 2'd1;
            lex_mode_next = M_IDLE;
          end
        end else begin
          if (held_bs) begin
            grp.res[n] = mk_res(ITEM_CONTENT, TK_CONTENT, CH_BSLASH);
            n = n + 2'd1;
          end
          held_bs_next = 1'b0;
          if (b == CH_NUL) begin
            grp.res[n] = mk_res(ITEM_END, TK_CONTENT, b);
            n = n + 2'd1;
            lex_mode_next = M_IDLE;
          end else if (b == CH_BSLASH) begin
            held_bs_next = 1'b1;
          end else begin
            grp.res[n] = mk_res(ITEM_CONTENT, TK_CONTENT, b);
            n = n + 2'd1;
          end
        end
      end
      M_COMMENT: begin
        if (b == CH_NUL) begin
          grp.res[n] = mk_res(ITEM_END, TK_LINEEND, b);
          n = n + 2'd1;
          lex_mode_next = M_IDLE;
          held_bs_next = 1'b0;
        end else if (is_eol(b)) begin
          lex_mode_next = M_LINEEND;
        end else begin
          grp.res[n] = mk_res(ITEM_CONTENT, TK_LINEEND, b);
          n = n + 2'd1;
        end
      end
      M_LINEEND: begin
        if (b == CH_SEMI) begin
          lex_mode_next = M_SKIPCMT;
        end else if (!is_eol(b)) begin
          grp.res[n] = mk_res(ITEM_END, TK_LINEEND, b);
          n = n + 2'd1;
          redo = 1'b1;
        end
      end
      M_SKIPCMT: begin
        if (b == CH_NUL) begin
          grp.res[n] = mk_res(ITEM_END, TK_LINEEND, b);
          n = n + 2'd1;
          lex_mode_next = M_IDLE;
          held_bs_next = 1'b0;
        end else if (is_eol(b)) begin
          lex_mode_next = M_LINEEND;
        end
      end
      default: begin
        redo = 1'b1;
      end
    endcase

    // start of a new token from idle
    if (redo) begin
      lex_mode_next = M_IDLE;
      held_bs_next  = 1'b0;
      if (b == CH_NUL || b == CH_SPACE || b == CH_TAB) begin
        lex_mode_next = M_IDLE;
      end else if (is_alpha(b) || b == CH_USCORE) begin
        grp.res[n] = mk_res(ITEM_CONTENT, TK_WORD, b);
        n = n + 2'd1;
        lex_mode_next = M_WORD;
      end else if (is_digit(b) || b == CH_DOLLAR || b == CH_PCT) begin
        grp.res[n] = mk_res(ITEM_CONTENT, TK_NUMBER, b);
        n = n + 2'd1;
        lex_mode_next = M_NUMBER;
      end else if (b == CH_HASH) begin
        lex_mode_next = M_INCLUDE;
      end else if (b == CH_DQUOTE) begin
        grp.res[n] = mk_res(ITEM_CONTENT, TK_TEXT, b);
        n = n + 2'd1;
        lex_mode_next = M_TEXT;
      end else if (b == CH_SQUOTE) begin
        grp.res[n] = mk_res(ITEM_CONTENT, TK_CHARS, b);
        n = n + 2'd1;
        lex_mode_next = M_CHARS;
      end else if (b == CH_LBRACE) begin
        lex_mode_next = M_CONTENT;
      end else if (b == CH_SEMI) begin
        lex_mode_next = M_COMMENT;
      end else if (is_punct(b)) begin
        grp.res[n] = mk_res(ITEM_CONTENT, TK_SPECIAL, b);
        n = n + 2'd1;
        grp.res[n] = mk_res(ITEM_END, TK_SPECIAL, b);
        n = n + 2'd1;
      end else if (is_eol(b)) begin
        lex_mode_next = M_LINEEND;
      end
    end

    grp.count = n;
    grp_valid = (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode <= M_IDLE;
      held_bs  <= 1'b0;
    end else if (take) begin
      lex_mode <= lex_mode_next;
      held_bs  <= held_bs_next;
    end
  end

endmodule

>>> rtl/core/sct_queue.sv
// ----------------------------------------------------------------------------
// sct_queue
// short register queue of result groups between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sct_queue
  import sct_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  grp_t wr_grp,
  output logic full,
  input  logic rd,
  output grp_t rd_grp,
  output logic avail
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  grp_t          slots [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full   = (count == CW'(DEPTH));
  assign avail  = (count != '0);
  assign rd_grp = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) slots[wptr] <= wr_grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (rd && avail) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      count <= count + CW'(wr && !full) - CW'(rd && avail);
    end
  end

endmodule

>>> rtl/core/sct_back.sv
// ----------------------------------------------------------------------------
// sct_back
// output register that hands out the words of one group, one per pop
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sct_back
  import sct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_avail,
  input  grp_t       q_grp,
  output logic       q_rd,
  output logic       empty,
  input  logic       pop,
  output logic       item_kind,
  output logic [2:0] token_kind,
  output logic [7:0] token_char
);

  grp_t       cur;
  logic       loaded;
  logic [1:0] idx;
  logic       last;
  res_t       head;

  assign head       = cur.res[idx];
  assign last       = (idx == cur.count - 2'd1);
  assign empty      = !loaded;
  assign item_kind  = head.kind;
  assign token_kind = head.tk;
  assign token_char = head.ch;
  assign q_rd       = (!loaded || (pop && last)) && q_avail;

  always_ff @(posedge clk) begin
    if (q_rd) cur <= q_grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
      idx    <= '0;
    end else if (q_rd) begin
      loaded <= 1'b1;
      idx    <= '0;
    end else if (loaded && pop) begin
      if (last) loaded <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

endmodule

>>> rtl/core/script_char_tokenizer.sv
// ----------------------------------------------------------------------------
// script_char_tokenizer
// script byte tokenizer: tags token content bytes and token ends
// ----------------------------------------------------------------------------
// usage:
//   input channel: drive in_char and raise push; the byte is taken at a clock
//   edge where push is high and full is low. a zero byte ends the script.
//   result channel: while empty is low the oldest word sits on item_kind,
//   token_kind and token_char; it is taken at an edge where pop is high.
//   each byte yields zero to three words.
// path: the words of a taken byte are written into the queue and then
//   loaded into the output register before they show on the result ports.
// throughput: one byte per cycle as long as the receiver keeps up; the
//   output side moves one word per cycle, so bytes giving two or three words
//   are drained more slowly than bytes are taken. a queue of QUEUE_DEPTH
//   word groups sits between the lexer and the output register.
// reset: lexer returns to idle between tokens, queue and output are emptied.
// stall: with pop low the output holds, the queue fills and full then holds
//   off further bytes; lexer state only moves on taken bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module script_char_tokenizer
  import sct_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char,
  output logic       empty,
  input  logic       pop,
  output logic       item_kind,
  output logic [2:0] token_kind,
  output logic [7:0] token_char
);

  logic take;
  grp_t f_grp;
  logic f_valid;
  grp_t q_grp;
  logic q_avail;
  logic q_rd;

  assign take = push && !full;

  sct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_char   (in_char),
    .grp       (f_grp),
    .grp_valid (f_valid)
  );

  sct_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (take && f_valid),
    .wr_grp (f_grp),
    .full   (full),
    .rd     (q_rd),
    .rd_grp (q_grp),
    .avail  (q_avail)
  );

  sct_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_avail    (q_avail),
    .q_grp      (q_grp),
    .q_rd       (q_rd),
    .empty      (empty),
    .pop        (pop),
    .item_kind  (item_kind),
    .token_kind (token_kind),
    .token_char (token_char)
  );

  `ASSERT_ON_CLK(a_end_char_zero, clk, rst, (!empty && item_kind) |-> (token_char == 8'h00))
  `ASSERT_ON_CLK(a_kind_range, clk, rst, !empty |-> (token_kind <= 3'd6))
  `ASSERT_ON_CLK(a_queued_grp_nonempty, clk, rst, q_rd |-> (q_grp.count != 2'd0))
  `ASSERT_AFTER_RST(a_reset_clear, clk, rst, empty && !full)

endmodule

>>> test/script_char_tokenizer_test.sv
// ----------------------------------------------------------------------------
// script_char_tokenizer_test
// self-checking bench for the script byte tokenizer: a short directed pass
// over every token kind and corner case, then random well-formed scripts with
// broken tokens mixed in, then raw byte noise. each accepted byte is run
// through a local scanner that queues the expected words; every popped word
// is checked field by field against the oldest queued one. both sides idle
// at random, with a stretch of full-rate traffic and a full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module script_char_tokenizer_test;
  import sct_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_char = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic       item_kind;
  logic [2:0] token_kind;
  logic [7:0] token_char;

  res_t       expected_words[$];
  lex_mode_t  scan_mode = M_IDLE;
  bit         escape_held = 1'b0;
  int         words_this_byte;
  int         bytes_sent = 0;
  int         mismatches = 0;
  int         pop_hold = 0;
  bit         steady = 1'b0;

  script_char_tokenizer dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_char   (in_char),
    .empty     (empty),
    .pop       (pop),
    .item_kind (item_kind),
    .token_kind(token_kind),
    .token_char(token_char)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1000000;
    $display("Test completed with failures");
    $finish;
  end

  // byte classes
  function automatic bit letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic bit numeral(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit punct_mark(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic bit line_break(input logic [7:0] c);
    return c == CH_CR || c == CH_LF;
  endfunction

  // scanner that predicts the words of each byte
  function automatic void emit(input item_kind_t k, input tok_kind_t t,
                               input logic [7:0] c);
    res_t w;
    if (words_this_byte >= MAX_RES) return;
    w.kind = k;
    w.tk   = t;
    w.ch   = (k == ITEM_END) ? 8'h00 : c;
    expected_words.insert(expected_words.size(), w);
    words_this_byte++;
  endfunction

  function automatic void end_token(input tok_kind_t t);
    emit(ITEM_END, t, 8'h00);
    scan_mode   = M_IDLE;
    escape_held = 1'b0;
  endfunction

  function automatic void begin_token(input logic [7:0] b);
    scan_mode   = M_IDLE;
    escape_held = 1'b0;
    if (b == CH_NUL || b == CH_SPACE || b == CH_TAB) return;
    if (letter(b) || b == CH_USCORE) begin
      emit(ITEM_CONTENT, TK_WORD, b);
      scan_mode = M_WORD;
    end else if (numeral(b) || b == CH_DOLLAR || b == CH_PCT) begin
      emit(ITEM_CONTENT, TK_NUMBER, b);
      scan_mode = M_NUMBER;
    end else if (b == CH_HASH) begin
      scan_mode = M_INCLUDE;
    end else if (b == CH_DQUOTE) begin
      emit(ITEM_CONTENT, TK_TEXT, b);
      scan_mode = M_TEXT;
    end else if (b == CH_SQUOTE) begin
      emit(ITEM_CONTENT, TK_CHARS, b);
      scan_mode = M_CHARS;
    end else if (b == CH_LBRACE) begin
      scan_mode = M_CONTENT;
    end else if (b == CH_SEMI) begin
      scan_mode = M_COMMENT;
    end else if (punct_mark(b)) begin
      emit(ITEM_CONTENT, TK_SPECIAL, b);
      emit(ITEM_END, TK_SPECIAL, 8'h00);
    end else if (line_break(b)) begin
      scan_mode = M_LINEEND;
    end
  endfunction

  // returns 1 when the byte closed the token and starts the next one
  function automatic bit quoted_step(input logic [7:0] b, input logic [7:0] q,
                                     input tok_kind_t t, input bit bs_escapes);
    if (escape_held) begin
      escape_held = 1'b0;
      if (b == q || (bs_escapes && b == CH_BSLASH)) begin
        emit(ITEM_CONTENT, t, b);
        return 1'b0;
      end
    end
    if (b == CH_BSLASH) begin
      emit(ITEM_CONTENT, t, b);
      escape_held = 1'b1;
      return 1'b0;
    end
    if (b == q) begin
      emit(ITEM_CONTENT, t, b);
      end_token(t);
      return 1'b0;
    end
    if (b == CH_NUL || line_break(b)) begin
      emit(ITEM_CONTENT, t, q);
      end_token(t);
      return 1'b1;
    end
    emit(ITEM_CONTENT, t, b);
    return 1'b0;
  endfunction

  function automatic bit token_step(input logic [7:0] b);
    case (scan_mode)
      M_WORD: begin
        if (letter(b) || numeral(b) || b == CH_USCORE) begin
          emit(ITEM_CONTENT, TK_WORD, b);
          return 1'b0;
        end
        end_token(TK_WORD);
        return 1'b1;
      end
      M_NUMBER: begin
        if (letter(b) || numeral(b) || b == CH_DOT) begin
          emit(ITEM_CONTENT, TK_NUMBER, b);
          return 1'b0;
        end
        end_token(TK_NUMBER);
        return 1'b1;
      end
      M_INCLUDE: begin
        if (b == CH_NUL || b == CH_HASH) scan_mode = M_IDLE;
        return 1'b0;
      end
      M_TEXT:  return quoted_step(b, CH_DQUOTE, TK_TEXT, 1'b1);
      M_CHARS: return quoted_step(b, CH_SQUOTE, TK_CHARS, 1'b0);
      M_CONTENT: begin
        if (b == CH_RBRACE) begin
          if (escape_held) begin
            escape_held = 1'b0;
            emit(ITEM_CONTENT, TK_CONTENT, b);
          end else begin
            end_token(TK_CONTENT);
          end
          return 1'b0;
        end
        if (escape_held) emit(ITEM_CONTENT, TK_CONTENT, CH_BSLASH);
        escape_held = 1'b0;
        if (b == CH_NUL) begin
          end_token(TK_CONTENT);
          return 1'b0;
        end
        if (b == CH_BSLASH) escape_held = 1'b1;
        else emit(ITEM_CONTENT, TK_CONTENT, b);
        return 1'b0;
      end
      M_COMMENT: begin
        if (b == CH_NUL) end_token(TK_LINEEND);
        else if (line_break(b)) scan_mode = M_LINEEND;
        else emit(ITEM_CONTENT, TK_LINEEND, b);
        return 1'b0;
      end
      M_LINEEND: begin
        if (line_break(b)) return 1'b0;
        if (b == CH_SEMI) begin
          scan_mode = M_SKIPCMT;
          return 1'b0;
        end
        end_token(TK_LINEEND);
        return 1'b1;
      end
      M_SKIPCMT: begin
        if (b == CH_NUL) end_token(TK_LINEEND);
        else if (line_break(b)) scan_mode = M_LINEEND;
        return 1'b0;
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    words_this_byte = 0;
    if (token_step(b)) begin_token(b);
  endfunction

  // idle lengths: mostly none or short, now and then long
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic logic [7:0] pick(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 2) != 0) c = 8'($urandom_range(32, 126));
      else c = 8'($urandom_range(1, 255));
    end while (line_break(c));
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_char <= b;
    do @(posedge clk); while (full);
    predict_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_for_all_words();
    push <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // receiver side
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 3) == 0) pop_hold = idle_cycles();
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    res_t w;
    if (!rst && pop && !empty) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind %0d token %0d char %0d", $time,
                 item_kind, token_kind, token_char);
        mismatches++;
      end else begin
        w = expected_words.pop_front();
        check_field("item_kind", w.kind, item_kind);
        check_field("token_kind", w.tk, token_kind);
        check_field("token_char", w.ch, token_char);
      end
    end
  end

  // word closed by a number, number closed by a special mark
  task automatic test_words_numbers();
    send_str("Z_9$.~");
  endtask

  // comment text, a line-end run, a skipped comment inside the run
  task automatic test_line_ends();
    send_str(";k");
    send_byte(CH_LF);
    send_str(";c");
    send_byte(CH_CR);
  endtask

  // escaped quote, high byte, char literal right after the closing quote,
  // left open until a line feed
  task automatic test_quoted();
    send_byte(CH_DQUOTE);
    send_byte(CH_BSLASH);
    send_byte(CH_DQUOTE);
    send_byte(8'hff);
    send_byte(CH_DQUOTE);
    send_byte(CH_SQUOTE);
    send_str("x");
    send_byte(CH_LF);
  endtask

  // escaped brace, held backslash flushed at end of script, include cut off
  // by end of script, end of script while idle
  task automatic test_content_include();
    send_byte(CH_LBRACE);
    send_byte(CH_BSLASH);
    send_byte(CH_RBRACE);
    send_byte(CH_BSLASH);
    send_byte(CH_NUL);
    send_str("#q");
    send_byte(CH_NUL);
    send_byte(CH_NUL);
  endtask

  task automatic send_quoted(input logic [7:0] q);
    int r;
    send_byte(q);
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(0, 4) == 0) begin
        send_byte(CH_BSLASH);
        send_byte($urandom_range(0, 2) == 0 ? CH_BSLASH : ($urandom_range(0, 1) ? q : 8'h6e));
      end else begin
        send_byte(body_byte());
      end
    end
    r = $urandom_range(0, 9);
    if (r < 7) send_byte(q);
    else if (r < 9) send_byte(pick("\n\015"));
    else send_byte(CH_NUL);
  endtask

  task automatic send_random_token();
    case ($urandom_range(0, 11))
      0, 1: begin
        send_byte(pick("_abzAZq"));
        repeat ($urandom_range(0, 5)) send_byte(pick("_azAZ09mK5"));
      end
      2: begin
        send_byte(pick("09$%7"));
        repeat ($urandom_range(0, 4)) send_byte(pick(".09afXZ"));
      end
      3: send_quoted(CH_DQUOTE);
      4: send_quoted(CH_SQUOTE);
      5: begin
        send_byte(CH_LBRACE);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 3) == 0) begin
            send_byte(CH_BSLASH);
            send_byte(pick("}\\ax"));
          end else begin
            send_byte(body_byte());
          end
        end
        send_byte($urandom_range(0, 4) != 0 ? CH_RBRACE : CH_NUL);
      end
      6: begin
        send_byte(CH_SEMI);
        repeat ($urandom_range(0, 4)) send_byte(body_byte());
        if ($urandom_range(0, 5) == 0) send_byte(CH_NUL);
        else repeat ($urandom_range(1, 2)) send_byte(pick("\n\015"));
      end
      7: begin
        repeat ($urandom_range(1, 3)) send_byte(pick("\n\015"));
        if ($urandom_range(0, 1)) begin
          send_byte(CH_SEMI);
          repeat ($urandom_range(0, 3)) send_byte(body_byte());
          send_byte($urandom_range(0, 4) != 0 ? pick("\n\015") : CH_NUL);
        end
      end
      8: begin
        send_byte(CH_HASH);
        repeat ($urandom_range(0, 3)) send_byte(pick("incldu.h<>"));
        send_byte($urandom_range(0, 5) != 0 ? CH_HASH : CH_NUL);
      end
      9: send_byte(pick("!&()*+,-/:<=>?@[]^`|~"));
      10: send_byte(pick(" \t"));
      default: begin
        if ($urandom_range(0, 2) == 0) send_byte(CH_NUL);
        else if ($urandom_range(0, 1)) send_byte(8'($urandom_range(128, 255)));
        else send_byte(8'($urandom_range(1, 31)));
      end
    endcase
  endtask

  task automatic test_random_scripts();
    int first;
    first = bytes_sent;
    while (bytes_sent - first < 270) begin
      steady = (bytes_sent - first >= 110) && (bytes_sent - first < 170);
      send_random_token();
    end
    steady = 1'b0;
  endtask

  task automatic test_random_noise();
    repeat (70) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_words_numbers();
    test_line_ends();
    test_quoted();
    test_content_include();
    wait_for_all_words();
    test_random_scripts();
    wait_for_all_words();
    test_random_noise();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
